// File: hdl/life_like_automaton_generation_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the life-like automaton generation core
// Concurrent checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LIFE_LIKE_AUTOMATON_GENERATION_CORE_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_GENERATION_CORE_ASSERT_SVH

`ifndef SYNTH

// property checked after reset
`define LLAG_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every edge, reset included
`define LLAG_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LLAG_ASSERT(name, clk, rst, prop, msg)
`define LLAG_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: hdl/llag_pkg.sv
// ---------------------------------------------------------------------------
// llag_pkg
// Shared types, register indexes and the cell rule.
// ---------------------------------------------------------------------------
package llag_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd5;

  // neighbour mask over the 3x3 window, center excluded
  localparam logic [8:0] NB_MASK    = 9'h1EF;
  // shift mask: clears column 2 (the newest-column slot) after a right shift
  localparam logic [8:0] SHIFT_MASK = 9'h0DB;

  typedef struct packed {
    logic [3:0] survive_low;
    logic [3:0] survive_high;
    logic [3:0] birth_low;
    logic [3:0] birth_high;
  } rule_cfg_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } line_req_t;

  // window bit row*3+col, row 0 on top, center bit 4
  function automatic logic cell_rule(logic [8:0] w, rule_cfg_t rc);
    logic [8:0] nb;
    logic [3:0] cnt;
    logic       res;
    nb  = w & NB_MASK;
    cnt = '0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + 4'(nb[i]);
    end
    if (w[4]) begin
      res = (cnt >= rc.survive_low) && (cnt <= rc.survive_high);
    end else begin
      res = (cnt >= rc.birth_low) && (cnt <= rc.birth_high);
    end
    return res;
  endfunction

endpackage

// File: hdl/llag_ram.sv
// ---------------------------------------------------------------------------
// llag_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module llag_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/llag_line_store.sv
// ---------------------------------------------------------------------------
// llag_line_store
// Upper and middle line buffers in one RAM, with per-entry valid bits so
// that entries never written since reset read as dead.
// ---------------------------------------------------------------------------
module llag_line_store #(
  parameter int MAX_COLS = 32,
  parameter int AW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  llag_pkg::line_req_t req,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic                wr_upper,
  input  logic                wr_middle,
  output logic                rd_upper,
  output logic                rd_middle
);
  import llag_pkg::*;

  logic [MAX_COLS-1:0] valid;
  logic                rd_valid;
  logic [1:0]          rd_data;

  llag_ram #(
    .WIDTH (2),
    .DEPTH (MAX_COLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr),
    .wr_addr (wr_addr),
    .wr_data ({wr_upper, wr_middle}),
    .rd_en   (req.rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr) begin
        valid[wr_addr] <= 1'b1;
      end
      if (req.rd) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_upper  = rd_data[1] & rd_valid;
  assign rd_middle = rd_data[0] & rd_valid;

endmodule

// File: hdl/life_like_automaton_generation_core.sv
// ---------------------------------------------------------------------------
// life_like_automaton_generation_core
// One generation of a life-like cellular automaton over a raster cell stream.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_write            cfg_index, cfg_data
//   in       in   in_valid / in_ready  cell_alive
//   out      out  out_valid / out_ready next_alive, last_of_frame
//
// Each item: line RAM read (S_IDLE), then read-modify-write (S_READ),
// then releases each result (S_EMIT_A, S_EMIT_B) while the output is free.
// The last cell of a frame then primes the flush window (S_FREAD, S_FSHIFT)
// and sweeps the line RAM with S_FREAD, S_FSHIFT, S_FEMIT for each column.
// Output stalls hold the block in its emit state.
// Reset clears line valid bits, position, state, out_valid and config.
// ---------------------------------------------------------------------------
module life_like_automaton_generation_core #(
  parameter int MAX_COLS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [llag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [llag_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cell_alive,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            next_alive,
  output logic                            last_of_frame
);
  import llag_pkg::*;

`include "life_like_automaton_generation_core_assert.svh"

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CAP = (MAX_COLS > 1) ? MAX_COLS - 1 : 1;
  localparam logic [6:0] CAP_W = 7'(CAP);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EMIT_A, S_EMIT_B, S_FREAD, S_FSHIFT, S_FEMIT
  } state_t;

  state_t     state;
  rule_cfg_t  rcfg;
  logic [15:0] grid_rows;
  logic [5:0]  grid_cols;

  logic [15:0]   row;
  logic [CW-1:0] col;
  logic [CW-1:0] fx;
  logic          cur_alive;
  logic [8:0]    window;
  logic [2:0]    fu;
  logic [2:0]    fm;
  logic          emit_b;
  logic          do_flush;
  logic          flush_upper;
  logic          fetch_zero;

  logic [15:0]   rows_eff;
  logic [CW-1:0] cols_eff;
  logic          last_col;
  logic          last_row;
  logic          slot_free;
  logic          emit_now;
  logic          fetch_ok;
  logic [8:0]    base;
  logic [8:0]    window_next;
  logic          u_in;

  line_req_t     req;
  logic [CW-1:0] rd_addr;
  logic          rd_upper;
  logic          rd_middle;

  always_ff @(posedge clk) begin
    if (rst) begin
      rcfg.survive_low  <= 4'd2;
      rcfg.survive_high <= 4'd3;
      rcfg.birth_low    <= 4'd3;
      rcfg.birth_high   <= 4'd3;
      grid_rows         <= 16'd32;
      grid_cols         <= 6'd32;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SURVIVE_LOW:  rcfg.survive_low  <= cfg_data[3:0];
        REG_SURVIVE_HIGH: rcfg.survive_high <= cfg_data[3:0];
        REG_BIRTH_LOW:    rcfg.birth_low    <= cfg_data[3:0];
        REG_BIRTH_HIGH:   rcfg.birth_high   <= cfg_data[3:0];
        REG_GRID_ROWS:    grid_rows         <= cfg_data[15:0];
        REG_GRID_COLS:    grid_cols         <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = (grid_rows == 16'd0) ? 16'd1 : grid_rows;
    if (grid_cols == 6'd0) begin
      cols_eff = CW'(1);
    end else if ({1'b0, grid_cols} > CAP_W) begin
      cols_eff = CW'(CAP);
    end else begin
      cols_eff = CW'(grid_cols);
    end
  end

  assign last_col  = ({1'b0, col} + (CW+1)'(1)) >= {1'b0, cols_eff};
  assign last_row  = ({1'b0, row} + 17'd1) >= {1'b0, rows_eff};
  assign slot_free = !out_valid || out_ready;
  assign emit_now  = slot_free
                   && ((state == S_EMIT_A) || (state == S_EMIT_B) || (state == S_FEMIT));
  assign fetch_ok  = fx < cols_eff;
  assign in_ready  = (state == S_IDLE);

  // window shift: upper masked above row 2, restart at column 0
  assign u_in        = (row >= 16'd2) ? rd_upper : 1'b0;
  assign base        = (col == '0) ? 9'd0 : window;
  assign window_next = ((base >> 1) & SHIFT_MASK)
                     | {cur_alive, 2'b00, rd_middle, 2'b00, u_in, 2'b00};

  assign req = line_req_t'{
    rd: (in_valid && state == S_IDLE) || (state == S_FREAD && fetch_ok),
    wr: (state == S_READ)
  };
  assign rd_addr = (state == S_IDLE) ? col : fx;

  llag_line_store #(
    .MAX_COLS (MAX_COLS),
    .AW       (CW)
  ) u_lines (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rd_addr   (rd_addr),
    .wr_addr   (col),
    .wr_upper  (rd_middle),
    .wr_middle (cur_alive),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_alive <= cell_alive;
            state     <= S_READ;
          end
        end
        S_READ: begin
          window      <= window_next;
          emit_b      <= (row != '0) && last_col;
          do_flush    <= last_col && last_row;
          flush_upper <= (row != '0);
          fx          <= '0;
          fu          <= '0;
          fm          <= '0;
          if (last_col) begin
            col <= '0;
            row <= last_row ? 16'd0 : row + 16'd1;
          end else begin
            col <= col + CW'(1);
          end
          if ((row != '0) && (col != '0)) begin
            state <= S_EMIT_A;
          end else if ((row != '0) && last_col) begin
            state <= S_EMIT_B;
          end else if (last_col && last_row) begin
            state <= S_FREAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT_A: begin
          if (slot_free) begin
            next_alive    <= cell_rule(window, rcfg);
            last_of_frame <= 1'b0;
            state         <= emit_b ? S_EMIT_B : (do_flush ? S_FREAD : S_IDLE);
          end
        end
        S_EMIT_B: begin
          if (slot_free) begin
            next_alive    <= cell_rule((window >> 1) & SHIFT_MASK, rcfg);
            last_of_frame <= 1'b0;
            state         <= do_flush ? S_FREAD : S_IDLE;
          end
        end
        S_FREAD: begin
          fetch_zero <= !fetch_ok;
          state      <= S_FSHIFT;
        end
        S_FSHIFT: begin
          fu <= {rd_upper & flush_upper & !fetch_zero, fu[2:1]};
          fm <= {rd_middle & !fetch_zero, fm[2:1]};
          if (fx == '0) begin
            fx    <= CW'(1);
            state <= S_FREAD;
          end else begin
            state <= S_FEMIT;
          end
        end
        S_FEMIT: begin
          if (slot_free) begin
            next_alive    <= cell_rule({3'b000, fm, fu}, rcfg);
            last_of_frame <= (fx == cols_eff);
            if (fx == cols_eff) begin
              state <= S_IDLE;
            end else begin
              fx    <= fx + CW'(1);
              state <= S_FREAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LLAG_ASSERT(a_one_item, clk, rst, (in_valid && in_ready) |=> !in_ready, "item overlap")
  `LLAG_ASSERT(a_no_ram_collision, clk, rst, !(req.rd && req.wr), "line RAM read/write clash")
  `LLAG_ASSERT(a_flush_primed, clk, rst, (state == S_FEMIT) |-> (fx != '0), "flush before prime")

endmodule
